// ===== sv/range_max_xor_trie_macros.svh =====
// assertion macros for the range max-xor trie checker
// used by rmxt_checker.sv, expects clk and rst_n in scope
`ifndef RANGE_MAX_XOR_TRIE_MACROS_SVH
`define RANGE_MAX_XOR_TRIE_MACROS_SVH

// clocked property, reset disables
`define RMXT_ASSERT(name, prop, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// same, checked during reset as well
`define RMXT_ASSERT_ALWAYS(name, prop, msg) \
    name: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== sv/rmxt_pkg.sv =====
// shared constants and types for the range max-xor trie
// no dependencies
`default_nettype none

package rmxt_pkg;

    localparam int MAX_ENTRIES_DEF = 1024;
    localparam int KEY_BITS_DEF    = 24;

    localparam logic OP_APPEND = 1'b0;
    localparam logic OP_QUERY  = 1'b1;

    localparam logic [1:0] STAT_OK        = 2'd0;
    localparam logic [1:0] STAT_BAD_RANGE = 2'd1;
    localparam logic [1:0] STAT_FULL      = 2'd2;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_I_ROOT,
        ST_I_PRIME,
        ST_I_LVL,
        ST_Q_ROOT,
        ST_Q_PRIME,
        ST_Q_ALT,
        ST_Q_CHK,
        ST_DONE
    } rmxt_state_t;

endpackage

`default_nettype wire

// ===== sv/rmxt_node_mem.sv =====
// trie node store: zero link, one link and pass count per node, two read ports
// uses rmxt_pkg; nodes 0..KEY_BITS+1 (null node and zero chain) are decoded
`default_nettype none

module rmxt_node_mem
    import rmxt_pkg::*;
#(
    parameter int MAX_ENTRIES = MAX_ENTRIES_DEF,
    parameter int KEY_BITS    = KEY_BITS_DEF,
    localparam int NODE_COUNT = 1 + (KEY_BITS + 1) * MAX_ENTRIES,
    localparam int NW         = $clog2(NODE_COUNT),
    localparam int CW         = $clog2(MAX_ENTRIES + 1)
)
(
    input  wire logic          clk,
    input  wire logic          wr_en,
    input  wire logic [NW-1:0] wr_addr,
    input  wire logic [NW-1:0] wr_zero,
    input  wire logic [NW-1:0] wr_one,
    input  wire logic [CW-1:0] wr_cnt,
    input  wire logic [NW-1:0] rd_addr_a,
    input  wire logic [NW-1:0] rd_addr_b,
    output logic      [NW-1:0] a_zero,
    output logic      [NW-1:0] a_one,
    output logic      [CW-1:0] a_cnt,
    output logic      [NW-1:0] b_zero,
    output logic      [NW-1:0] b_one,
    output logic      [CW-1:0] b_cnt
);

    localparam int DW = 2 * NW + CW;

    logic [DW-1:0] mem [NODE_COUNT];
    logic [DW-1:0] q_a_reg;
    logic [DW-1:0] q_b_reg;
    logic [NW-1:0] addr_a_reg;
    logic [NW-1:0] addr_b_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= {wr_zero, wr_one, wr_cnt};
        end
        q_a_reg    <= mem[rd_addr_a];
        q_b_reg    <= mem[rd_addr_b];
        addr_a_reg <= rd_addr_a;
        addr_b_reg <= rd_addr_b;
    end

    // fixed nodes: null node, then the zero-prefix chain
    function automatic logic [DW-1:0] decode(input logic [NW-1:0] addr,
                                             input logic [DW-1:0] q);
        logic [DW-1:0] d;
        d = q;
        if (addr == '0)
        begin
            d = '0;
        end
        else if (addr <= NW'(KEY_BITS))
        begin
            d = {NW'(addr + NW'(1)), NW'(0), CW'(1)};
        end
        else if (addr == NW'(KEY_BITS + 1))
        begin
            d = {NW'(0), NW'(0), CW'(1)};
        end
        return d;
    endfunction

    assign {a_zero, a_one, a_cnt} = decode(addr_a_reg, q_a_reg);
    assign {b_zero, b_one, b_cnt} = decode(addr_b_reg, q_b_reg);

endmodule

`default_nettype wire

// ===== sv/rmxt_root_mem.sv =====
// version root table, one write port and two read ports
// uses rmxt_pkg; versions 0 and 1 are decoded
`default_nettype none

module rmxt_root_mem
    import rmxt_pkg::*;
#(
    parameter int MAX_ENTRIES = MAX_ENTRIES_DEF,
    parameter int KEY_BITS    = KEY_BITS_DEF,
    localparam int NODE_COUNT = 1 + (KEY_BITS + 1) * MAX_ENTRIES,
    localparam int NW         = $clog2(NODE_COUNT),
    localparam int VW         = $clog2(MAX_ENTRIES + 1)
)
(
    input  wire logic          clk,
    input  wire logic          wr_en,
    input  wire logic [VW-1:0] wr_idx,
    input  wire logic [NW-1:0] wr_root,
    input  wire logic [VW-1:0] rd_idx_a,
    input  wire logic [VW-1:0] rd_idx_b,
    output logic      [NW-1:0] root_a,
    output logic      [NW-1:0] root_b
);

    logic [NW-1:0] mem [MAX_ENTRIES + 1];
    logic [NW-1:0] q_a_reg;
    logic [NW-1:0] q_b_reg;
    logic [VW-1:0] idx_a_reg;
    logic [VW-1:0] idx_b_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_idx] <= wr_root;
        end
        q_a_reg   <= mem[rd_idx_a];
        q_b_reg   <= mem[rd_idx_b];
        idx_a_reg <= rd_idx_a;
        idx_b_reg <= rd_idx_b;
    end

    function automatic logic [NW-1:0] decode(input logic [VW-1:0] idx,
                                             input logic [NW-1:0] q);
        logic [NW-1:0] r;
        r = q;
        if (idx == '0)
        begin
            r = '0;
        end
        else if (idx == VW'(1))
        begin
            r = NW'(1);
        end
        return r;
    endfunction

    assign root_a = decode(idx_a_reg, q_a_reg);
    assign root_b = decode(idx_b_reg, q_b_reg);

endmodule

`default_nettype wire

// ===== sv/range_max_xor_trie.sv =====
// range max-xor trie top level: sequencer, node store and root table
// uses rmxt_pkg, rmxt_node_mem, rmxt_root_mem
//
// one beat in on s_axis, one beat out on m_axis for every beat in.
// s_axis_tuser is the opcode (append or query); s_axis_tdata carries the
// value and the 1-based range. m_axis_tdata is the best xor, m_axis_tuser
// the status (ok, bad range, store full).
// an append walks KEY_BITS+1 nodes, one node write per cycle through the
// node store port. a query walks KEY_BITS levels, one or two node-store
// reads per level. bad range and full store go straight from idle to the
// result, with no change to the store.
// s_axis_tready is high only while the sequencer is idle; one item at a time.
// the result sits in an output register; a stalled m_axis holds it and the
// block can take the next item meanwhile, but the next result waits.
// reset holds only the zero prefix as entry 1; no clearing pass is needed.
`default_nettype none

module range_max_xor_trie
    import rmxt_pkg::*;
#(
    parameter int MAX_ENTRIES = MAX_ENTRIES_DEF,
    parameter int KEY_BITS    = KEY_BITS_DEF
)
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [47:0] s_axis_tdata,  // operand_value, range_left, range_right
    input  wire logic        s_axis_tuser,  // opcode
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic      [23:0] m_axis_tdata,  // max_xor
    output logic      [1:0]  m_axis_tuser   // status
);

    localparam int NODE_COUNT = 1 + (KEY_BITS + 1) * MAX_ENTRIES;
    localparam int NW         = $clog2(NODE_COUNT);
    localparam int CW         = $clog2(MAX_ENTRIES + 1);
    localparam int VW         = $clog2(MAX_ENTRIES + 1);
    localparam int LW         = $clog2(KEY_BITS + 1);

    logic [23:0] operand_value;
    logic [10:0] range_left;
    logic [10:0] range_right;
    assign operand_value = s_axis_tdata[23:0];
    assign range_left    = s_axis_tdata[34:24];
    assign range_right   = s_axis_tdata[45:35];

    rmxt_state_t state_reg, state_next;
    logic [KEY_BITS-1:0] run_xor_reg, run_xor_next;
    logic [VW-1:0]       count_reg, count_next;
    logic [NW-1:0]       free_reg, free_next;
    logic [NW-1:0]       cur_reg, cur_next;
    logic [KEY_BITS-1:0] key_reg, key_next;
    logic [KEY_BITS-1:0] ans_reg, ans_next;
    logic [LW-1:0]       lvl_reg, lvl_next;
    logic [1:0]          stat_reg, stat_next;
    logic [VW-1:0]       idx_a_reg, idx_a_next;
    logic [VW-1:0]       idx_b_reg, idx_b_next;
    logic [NW-1:0]       alt_lo_reg, alt_lo_next;
    logic [NW-1:0]       alt_hi_reg, alt_hi_next;
    logic                m_valid_reg, m_valid_next;
    logic [23:0]         m_data_reg, m_data_next;
    logic [1:0]          m_user_reg, m_user_next;

    logic          n_wr_en;
    logic [NW-1:0] n_wr_zero, n_wr_one;
    logic [CW-1:0] n_wr_cnt;
    logic [NW-1:0] rd_a, rd_b;
    logic [NW-1:0] a_zero, a_one, b_zero, b_one;
    logic [CW-1:0] a_cnt, b_cnt;
    logic          r_wr_en;
    logic [NW-1:0] root_a, root_b;

    logic [KEY_BITS-1:0] key_in;
    logic [KEY_BITS-1:0] key_sh;
    logic                kbit, nbit;
    logic                range_ok;

    assign key_in   = run_xor_reg ^ KEY_BITS'(operand_value);
    assign key_sh   = key_reg << 1;
    assign kbit     = key_reg[KEY_BITS-1];
    assign nbit     = key_sh[KEY_BITS-1];
    assign range_ok = (range_left != '0) && (range_left <= range_right)
                      && (32'(range_right) <= 32'(count_reg));

    rmxt_node_mem #(.MAX_ENTRIES(MAX_ENTRIES), .KEY_BITS(KEY_BITS)) u_node
    (
        .clk       (clk),
        .wr_en     (n_wr_en),
        .wr_addr   (cur_reg),
        .wr_zero   (n_wr_zero),
        .wr_one    (n_wr_one),
        .wr_cnt    (n_wr_cnt),
        .rd_addr_a (rd_a),
        .rd_addr_b (rd_b),
        .a_zero    (a_zero),
        .a_one     (a_one),
        .a_cnt     (a_cnt),
        .b_zero    (b_zero),
        .b_one     (b_one),
        .b_cnt     (b_cnt)
    );

    rmxt_root_mem #(.MAX_ENTRIES(MAX_ENTRIES), .KEY_BITS(KEY_BITS)) u_root
    (
        .clk      (clk),
        .wr_en    (r_wr_en),
        .wr_idx   (VW'(count_reg + VW'(1))),
        .wr_root  (free_reg),
        .rd_idx_a (idx_a_reg),
        .rd_idx_b (idx_b_reg),
        .root_a   (root_a),
        .root_b   (root_b)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_IDLE;
            run_xor_reg <= '0;
            count_reg   <= VW'(1);
            free_reg    <= NW'(KEY_BITS + 2);
            m_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            run_xor_reg <= run_xor_next;
            count_reg   <= count_next;
            free_reg    <= free_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cur_reg    <= cur_next;
        key_reg    <= key_next;
        ans_reg    <= ans_next;
        lvl_reg    <= lvl_next;
        stat_reg   <= stat_next;
        idx_a_reg  <= idx_a_next;
        idx_b_reg  <= idx_b_next;
        alt_lo_reg <= alt_lo_next;
        alt_hi_reg <= alt_hi_next;
        m_data_reg <= m_data_next;
        m_user_reg <= m_user_next;
    end

    always_comb
    begin
        state_next   = state_reg;
        run_xor_next = run_xor_reg;
        count_next   = count_reg;
        free_next    = free_reg;
        cur_next     = cur_reg;
        key_next     = key_reg;
        ans_next     = ans_reg;
        lvl_next     = lvl_reg;
        stat_next    = stat_reg;
        idx_a_next   = idx_a_reg;
        idx_b_next   = idx_b_reg;
        alt_lo_next  = alt_lo_reg;
        alt_hi_next  = alt_hi_reg;
        m_valid_next = m_valid_reg && !m_axis_tready;
        m_data_next  = m_data_reg;
        m_user_next  = m_user_reg;
        n_wr_en      = 1'b0;
        n_wr_zero    = a_zero;
        n_wr_one     = a_one;
        n_wr_cnt     = CW'(a_cnt + CW'(1));
        r_wr_en      = 1'b0;
        rd_a         = alt_lo_reg;
        rd_b         = alt_hi_reg;
        s_axis_tready = (state_reg == ST_IDLE);

        unique case (state_reg)
            ST_IDLE:
            begin
                if (s_axis_tvalid)
                begin
                    key_next   = key_in;
                    ans_next   = '0;
                    lvl_next   = LW'(KEY_BITS);
                    cur_next   = free_reg;
                    stat_next  = STAT_OK;
                    idx_a_next = count_reg;
                    idx_b_next = VW'(range_right);
                    if (s_axis_tuser == OP_APPEND)
                    begin
                        if (count_reg == VW'(MAX_ENTRIES))
                        begin
                            stat_next  = STAT_FULL;
                            state_next = ST_DONE;
                        end
                        else
                        begin
                            run_xor_next = key_in;
                            state_next   = ST_I_ROOT;
                        end
                    end
                    else
                    begin
                        idx_a_next = VW'(range_left - 11'd1);
                        if (range_ok)
                        begin
                            state_next = ST_Q_ROOT;
                        end
                        else
                        begin
                            stat_next  = STAT_BAD_RANGE;
                            state_next = ST_DONE;
                        end
                    end
                end
            end
            ST_I_ROOT:
            begin
                state_next = ST_I_PRIME;
            end
            ST_I_PRIME:
            begin
                rd_a       = root_a;
                state_next = ST_I_LVL;
            end
            ST_I_LVL:
            begin
                n_wr_en  = 1'b1;
                cur_next = cur_reg + NW'(1);
                if (lvl_reg != '0)
                begin
                    n_wr_zero = kbit ? a_zero : NW'(cur_reg + NW'(1));
                    n_wr_one  = kbit ? NW'(cur_reg + NW'(1)) : a_one;
                    rd_a      = kbit ? a_one : a_zero;
                    key_next  = key_sh;
                    lvl_next  = lvl_reg - LW'(1);
                end
                else
                begin
                    // leaf node
                    n_wr_zero    = '0;
                    n_wr_one     = '0;
                    r_wr_en      = 1'b1;
                    count_next   = count_reg + VW'(1);
                    free_next    = NW'(free_reg + NW'(KEY_BITS + 1));
                    state_next   = ST_DONE;
                end
            end
            ST_Q_ROOT:
            begin
                state_next = ST_Q_PRIME;
            end
            ST_Q_PRIME:
            begin
                rd_a       = root_a;
                rd_b       = root_b;
                state_next = ST_Q_ALT;
            end
            ST_Q_ALT:
            begin
                rd_a        = kbit ? a_zero : a_one;
                rd_b        = kbit ? b_zero : b_one;
                alt_lo_next = kbit ? a_one : a_zero;
                alt_hi_next = kbit ? b_one : b_zero;
                state_next  = ST_Q_CHK;
            end
            ST_Q_CHK:
            begin
                key_next = key_sh;
                lvl_next = lvl_reg - LW'(1);
                if (a_cnt != b_cnt)
                begin
                    ans_next    = (ans_reg << 1) | KEY_BITS'(1);
                    rd_a        = nbit ? a_zero : a_one;
                    rd_b        = nbit ? b_zero : b_one;
                    alt_lo_next = nbit ? a_one : a_zero;
                    alt_hi_next = nbit ? b_one : b_zero;
                    state_next  = (lvl_reg == LW'(1)) ? ST_DONE : ST_Q_CHK;
                end
                else
                begin
                    ans_next   = ans_reg << 1;
                    state_next = (lvl_reg == LW'(1)) ? ST_DONE : ST_Q_ALT;
                end
            end
            ST_DONE:
            begin
                if (!m_valid_reg || m_axis_tready)
                begin
                    m_valid_next = 1'b1;
                    m_data_next  = 24'(ans_reg);
                    m_user_next  = stat_reg;
                    state_next   = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tdata  = m_data_reg;
    assign m_axis_tuser  = m_user_reg;

endmodule

`default_nettype wire

// ===== sv/rmxt_checker.sv =====
// port-level checks for range_max_xor_trie, bound to the top level
// uses rmxt_pkg and range_max_xor_trie_macros.svh
`default_nettype none
`include "range_max_xor_trie_macros.svh"

module rmxt_checker
    import rmxt_pkg::*;
(
    input wire logic        clk,
    input wire logic        rst_n,
    input wire logic        s_axis_tvalid,
    input wire logic        s_axis_tready,
    input wire logic [47:0] s_axis_tdata,
    input wire logic        s_axis_tuser,
    input wire logic        m_axis_tvalid,
    input wire logic        m_axis_tready,
    input wire logic [23:0] m_axis_tdata,
    input wire logic [1:0]  m_axis_tuser
);

    `RMXT_ASSERT(a_busy_after_accept, (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready, "ready after accept")
    `RMXT_ASSERT(a_status_code, m_axis_tvalid |-> (m_axis_tuser == STAT_OK || m_axis_tuser == STAT_BAD_RANGE || m_axis_tuser == STAT_FULL), "bad status")
    `RMXT_ASSERT(a_error_zero, (m_axis_tvalid && m_axis_tuser != STAT_OK) |-> (m_axis_tdata == 24'd0), "error with data")
    `RMXT_ASSERT(a_out_hold, (m_axis_tvalid && !m_axis_tready) |=> (m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser)), "output beat dropped")
    `RMXT_ASSERT_ALWAYS(a_reset_idle, !rst_n |-> !m_axis_tvalid, "valid in reset")

endmodule

bind range_max_xor_trie rmxt_checker u_rmxt_checker (.*);

`default_nettype wire

// ===== dv/tb_range_max_xor_trie.sv =====
// testbench for range_max_xor_trie: appends and range max-xor queries on the stream ports
// depends on rmxt_pkg and range_max_xor_trie; predicts results from a list of stored prefixes
`timescale 1ns / 100ps

module tb_range_max_xor_trie;
    import rmxt_pkg::*;

    localparam int  CAP        = 1024;
    localparam int  CYCLE_CAP  = 1500000;

    typedef struct packed {
        logic [23:0] max_xor;
        logic [1:0]  status;
    } answer_t;

    logic        clk;
    logic        rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [47:0] s_axis_tdata;
    logic        s_axis_tuser;
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [23:0] m_axis_tdata;
    logic [1:0]  m_axis_tuser;

    logic [23:0] prefix_store [1:CAP];
    int          stored;
    logic [23:0] xor_acc;
    answer_t     pending_answers [$];
    int          idle_pct;
    int          stall_pct;
    int          mismatches;
    int          cycles;

    range_max_xor_trie u_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    initial clk = 1'b0;
    always #5 clk = ~clk;

    function automatic answer_t trie_answer(logic op, logic [23:0] val,
                                            logic [10:0] lft, logic [10:0] rgt);
        answer_t     a;
        logic [23:0] key;
        a.max_xor = '0;
        a.status  = STAT_OK;
        if (op == OP_APPEND) begin
            if (stored >= CAP)
                a.status = STAT_FULL;
            else begin
                xor_acc = xor_acc ^ val;
                stored++;
                prefix_store[stored] = xor_acc;
            end
        end
        else if (lft < 1 || lft > rgt || rgt > stored)
            a.status = STAT_BAD_RANGE;
        else begin
            key = xor_acc ^ val;
            for (int i = lft; i <= rgt; i++)
                if ((key ^ prefix_store[i]) > a.max_xor)
                    a.max_xor = key ^ prefix_store[i];
        end
        return a;
    endfunction

    task automatic send_beat(logic op, logic [23:0] val, logic [10:0] lft, logic [10:0] rgt);
        while ($urandom_range(99) < idle_pct) begin
            s_axis_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= op;
        s_axis_tdata  <= {2'b00, rgt, lft, val};
        @(posedge clk);
        while (!s_axis_tready) @(posedge clk);
        pending_answers.push_back(trie_answer(op, val, lft, rgt));
    endtask

    task automatic send_query_random();
        logic [10:0] r;
        logic [10:0] l;
        if ($urandom_range(9) == 0) begin
            l = 11'($urandom_range(CAP));
            r = 11'($urandom_range(CAP));
        end
        else begin
            r = 11'($urandom_range(stored, 1));
            l = ($urandom_range(3) == 0) ? 11'd1 : 11'($urandom_range(r, 1));
        end
        send_beat(OP_QUERY, 24'($urandom), l, r);
    endtask

    task automatic test_directed();
        send_beat(OP_QUERY, 24'h000000, 11'd1, 11'd1);
        send_beat(OP_QUERY, 24'hFFFFFF, 11'd1, 11'd1);
        send_beat(OP_APPEND, 24'hFFFFFF, 11'd0, 11'd0);
        send_beat(OP_APPEND, 24'h000000, 11'd0, 11'd0);
        send_beat(OP_APPEND, 24'h800000, 11'h7FF, 11'h7FF);
        send_beat(OP_APPEND, 24'h000001, 11'd5, 11'd2);
        send_beat(OP_APPEND, 24'h5A5A5A, 11'd0, 11'd0);
        send_beat(OP_QUERY, 24'h000000, 11'd1, 11'd6);
        send_beat(OP_QUERY, 24'hFFFFFF, 11'd1, 11'd6);
        send_beat(OP_QUERY, 24'h123456, 11'd2, 11'd5);
        send_beat(OP_QUERY, 24'hABCDEF, 11'd4, 11'd4);
        send_beat(OP_QUERY, 24'h0F0F0F, 11'd6, 11'd6);
        send_beat(OP_QUERY, 24'h000000, 11'd0, 11'd3);
        send_beat(OP_QUERY, 24'h000000, 11'd4, 11'd3);
        send_beat(OP_QUERY, 24'h000000, 11'd1, 11'd7);
        send_beat(OP_QUERY, 24'hFFFFFF, 11'd1, 11'd1024);
        send_beat(OP_QUERY, 24'hFFFFFF, 11'd1024, 11'd1024);
        send_beat(OP_QUERY, 24'h7FFFFF, 11'd2, 11'd6);
    endtask

    task automatic test_random(int count, int idle, int stall);
        idle_pct  = idle;
        stall_pct = stall;
        repeat (count) begin
            if ($urandom_range(99) < 80 && stored < CAP)
                send_beat(OP_APPEND, 24'($urandom), 11'($urandom), 11'($urandom));
            else
                send_query_random();
        end
    endtask

    task automatic test_full_store();
        idle_pct  = 10;
        stall_pct = 10;
        while (stored < CAP) begin
            send_beat(OP_APPEND, 24'($urandom), 11'd0, 11'd0);
            if ($urandom_range(31) == 0)
                send_query_random();
        end
        send_beat(OP_APPEND, 24'hFFFFFF, 11'd0, 11'd0);
        send_beat(OP_APPEND, 24'h000000, 11'd1, 11'd1024);
        send_beat(OP_QUERY, 24'h000000, 11'd1, 11'd1024);
        send_beat(OP_QUERY, 24'hFFFFFF, 11'd1, 11'd1024);
        send_beat(OP_QUERY, 24'h3C3C3C, 11'd1024, 11'd1024);
        send_beat(OP_QUERY, 24'h000000, 11'd1023, 11'd1024);
        send_beat(OP_QUERY, 24'h000000, 11'd1024, 11'd1023);
        repeat (20) send_query_random();
    endtask

    always @(posedge clk) begin
        m_axis_tready <= ($urandom_range(99) >= stall_pct);
    end

    always @(posedge clk) begin
        answer_t want;
        if (rst_n && m_axis_tvalid && m_axis_tready) begin
            if (pending_answers.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected beat: max_xor %h status %0d", m_axis_tdata, m_axis_tuser);
            end
            else begin
                want = pending_answers.pop_front();
                if (want.max_xor !== m_axis_tdata || want.status !== m_axis_tuser) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch: max_xor exp %h got %h, status exp %0d got %0d",
                                 want.max_xor, m_axis_tdata, want.status, m_axis_tuser);
                end
            end
        end
    end

    always @(posedge clk) begin
        cycles++;
        if (cycles > CYCLE_CAP) begin
            $display("FAIL range_max_xor_trie");
            $finish;
        end
    end

    initial begin
        rst_n         = 1'b1;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tuser  = OP_APPEND;
        m_axis_tready = 1'b0;
        idle_pct      = 0;
        stall_pct     = 0;
        mismatches    = 0;
        cycles        = 0;
        stored        = 1;
        xor_acc       = '0;
        prefix_store[1] = '0;
        #1 rst_n = 1'b0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed();
        test_random(100, 0, 0);
        test_random(100, 73, 0);
        test_random(100, 0, 73);
        test_random(100, 26, 26);
        test_full_store();
        s_axis_tvalid <= 1'b0;

        while (pending_answers.size() != 0) @(posedge clk);
        repeat (60) @(posedge clk);
        if (mismatches == 0)
            $display("PASS range_max_xor_trie");
        else
            $display("FAIL range_max_xor_trie");
        $finish;
    end
endmodule

// ===== filelist.f =====
+incdir+sv
sv/rmxt_pkg.sv
sv/rmxt_node_mem.sv
sv/rmxt_root_mem.sv
sv/range_max_xor_trie.sv
sv/rmxt_checker.sv
dv/tb_range_max_xor_trie.sv
